// ===== design/ccsm_pkg.sv =====
// Shared types and constants for the cluster cache slot manager.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package ccsm_pkg;

  localparam int DEF_SLOTS  = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRITE_BACK = 1'd0,
    CFG_READ_ONLY  = 1'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_ACQUIRE = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_DIRTY   = 2'd2,
    MODE_DELETE  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    STS_HIT       = 4'd0,
    STS_FILL      = 4'd1,
    STS_CLEAN_EV  = 4'd2,
    STS_DIRTY_EV  = 4'd3,
    STS_FULL      = 4'd4,
    STS_RELEASED  = 4'd5,
    STS_DIRTIED   = 4'd6,
    STS_WRITE_THR = 4'd7,
    STS_READ_ONLY = 4'd8,
    STS_IGNORED   = 4'd9,
    STS_DELETED   = 4'd10
  } status_e;

  typedef enum logic [2:0] {
    SS_FREE    = 3'd0,
    SS_VALID   = 3'd1,
    SS_DIRTY_N = 3'd2,
    SS_DIRTY_U = 3'd3,
    SS_DELETED = 3'd4
  } sstate_e;

  typedef struct packed {
    logic [2:0]  state;
    logic [7:0]  users;
    logic [31:0] stamp;
    logic [15:0] device;
    logic [27:0] cluster;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SCAN,
    CS_ROT,
    CS_FETCH,
    CS_EXEC
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic eval;
    logic rot_phase;
    logic start_rot;
    logic fetch;
    logic exec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_rot;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/ccsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ccsm_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== design/ccsm_ctrl.sv =====
// Controller state machine: sequences the tag scan, the rotating scan and
// the read-modify-write of one slot. Depends on ccsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ccsm_ctrl #(
  parameter int SLOTS = ccsm_pkg::DEF_SLOTS
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [1:0]     mode_i,
  output logic                in_stall_o,
  input  wire ccsm_pkg::sts_t sts_i,
  output ccsm_pkg::cmd_t      cmd_o
);
  import ccsm_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);

  ctrl_state_e     state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            rd_v_q;
  logic            scan_done;

  assign scan_done = (cnt_q == CW'(SLOTS)) && !rd_v_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (in_valid_i) begin
          if (mode_i == MODE_ACQUIRE || mode_i == MODE_DELETE) begin
            state_d = CS_SCAN;
          end else begin
            state_d = CS_FETCH;
          end
        end
      end
      CS_SCAN: begin
        if (scan_done) begin
          state_d = sts_i.need_rot ? CS_ROT : CS_FETCH;
        end
      end
      CS_ROT: begin
        if (scan_done) begin
          state_d = CS_FETCH;
        end
      end
      CS_FETCH: state_d = CS_EXEC;
      CS_EXEC: begin
        if (sts_i.out_free) begin
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      CS_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      CS_SCAN: begin
        cmd_o.issue     = (cnt_q < CW'(SLOTS));
        cmd_o.eval      = rd_v_q;
        cmd_o.start_rot = scan_done && sts_i.need_rot;
      end
      CS_ROT: begin
        cmd_o.issue     = (cnt_q < CW'(SLOTS));
        cmd_o.eval      = rd_v_q;
        cmd_o.rot_phase = 1'b1;
      end
      CS_FETCH: cmd_o.fetch = 1'b1;
      CS_EXEC:  cmd_o.exec  = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  // scan counter: restart on a new transaction and on the rotating scan
  always_comb begin
    cnt_d = cnt_q;
    if (state_q == CS_IDLE || cmd_o.start_rot) begin
      cnt_d = '0;
    end else if (cmd_o.issue) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      cnt_q   <= '0;
      rd_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rd_v_q  <= cmd_o.issue;
    end
  end

endmodule
`default_nettype wire

// ===== design/ccsm_dp.sv =====
// Datapath: slot table RAM, per-slot valid bits, scan trackers, the
// read-modify-write update and the result register. Depends on ccsm_pkg, ccsm_ram.
`timescale 1ns / 1ps
`default_nettype none
module ccsm_dp #(
  parameter int SLOTS = ccsm_pkg::DEF_SLOTS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire ccsm_pkg::cmd_t                  cmd_i,
  output ccsm_pkg::sts_t                       sts_o,
  input  wire logic [1:0]                      mode_i,
  input  wire logic [15:0]                     device_i,
  input  wire logic [27:0]                     cluster_i,
  input  wire logic [5:0]                      slot_i,
  input  wire logic [31:0]                     now_i,
  input  wire logic                            uncompressed_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [ccsm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ccsm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [3:0]                           status_o,
  output logic [5:0]                           slot_out_o,
  output logic [15:0]                          evict_device_o,
  output logic [27:0]                          evict_cluster_o,
  output logic                                 evict_uncompressed_o
);
  import ccsm_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  // item registers
  mode_e        mode_q;
  logic [15:0]  dev_q;
  logic [27:0]  clu_q;
  logic [5:0]   slot_q;
  logic [31:0]  now_q;
  logic         ucf_q;

  // configuration and control state
  logic         wbe_q, ro_q;
  logic [SLOTS-1:0] v_q;
  logic [AW-1:0] ptr_q, ptr_d;
  logic         out_valid_q;

  // scan trackers
  logic          hit_f_q, free_f_q, old_f_q, rot_f_q;
  logic [AW-1:0] hit_q, free_q, old_q, rot_q;
  logic [31:0]   otime_q;
  logic [AW-1:0] scan_addr_q, rd_addr_q, target_q, target_sel, raddr;

  // ram
  logic [ENTRY_W-1:0] rdata;
  entry_t        eff, wr;
  logic          we;
  logic          tag_match, in_range;

  // result
  status_e       st;
  logic [5:0]    sout;
  logic [15:0]   edev;
  logic [27:0]   eclu;
  logic          euc;

  ccsm_ram #(.Width(ENTRY_W), .Depth(SLOTS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(target_q),
    .wdata_i(wr),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // a slot never written reads as free, idle and time zero
  assign eff = v_q[rd_addr_q] ? entry_t'(rdata) : '0;

  assign tag_match = (eff.state == SS_VALID || eff.state == SS_DIRTY_N ||
                      eff.state == SS_DIRTY_U) &&
                     eff.device == dev_q && eff.cluster == clu_q;

  assign in_range = (int'(slot_q) < SLOTS);

  // pick the slot to read-modify-write
  always_comb begin
    case (mode_q)
      MODE_ACQUIRE: target_sel = hit_f_q ? hit_q : free_f_q ? free_q :
                                 old_f_q ? old_q : rot_q;
      MODE_RELEASE: target_sel = AW'(slot_q);
      MODE_DIRTY:   target_sel = AW'(slot_q);
      MODE_DELETE:  target_sel = hit_q;
      default:      target_sel = hit_q;
    endcase
  end

  assign raddr = cmd_i.issue ? scan_addr_q : (cmd_i.fetch ? target_sel : target_q);

  assign sts_o.need_rot = (mode_q == MODE_ACQUIRE) && !hit_f_q && !free_f_q && !old_f_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // latch the item and track the scans
  always_ff @(posedge clk_i) begin
    rd_addr_q <= raddr;
    if (cmd_i.load) begin
      mode_q      <= mode_e'(mode_i);
      dev_q       <= device_i;
      clu_q       <= cluster_i;
      slot_q      <= slot_i;
      now_q       <= now_i;
      ucf_q       <= uncompressed_i;
      otime_q     <= now_i;
      hit_f_q     <= 1'b0;
      free_f_q    <= 1'b0;
      old_f_q     <= 1'b0;
      rot_f_q     <= 1'b0;
      scan_addr_q <= '0;
    end else if (cmd_i.start_rot) begin
      scan_addr_q <= (ptr_q == LAST) ? '0 : ptr_q + AW'(1);
    end else if (cmd_i.issue) begin
      scan_addr_q <= (scan_addr_q == LAST) ? '0 : scan_addr_q + AW'(1);
    end
    if (cmd_i.eval && !cmd_i.rot_phase && !hit_f_q) begin
      if (eff.state == SS_FREE) begin
        free_f_q <= 1'b1;
        free_q   <= rd_addr_q;
      end else begin
        if (eff.users == 8'd0 && eff.stamp < otime_q) begin
          old_f_q <= 1'b1;
          old_q   <= rd_addr_q;
          otime_q <= eff.stamp;
        end
        if (tag_match) begin
          hit_f_q <= 1'b1;
          hit_q   <= rd_addr_q;
        end
      end
    end
    if (cmd_i.eval && cmd_i.rot_phase && !rot_f_q && eff.users == 8'd0) begin
      rot_f_q <= 1'b1;
      rot_q   <= rd_addr_q;
    end
    if (cmd_i.fetch) begin
      target_q <= target_sel;
    end
  end

  // update the slot and form the result
  always_comb begin
    wr    = eff;
    we    = 1'b0;
    st    = STS_IGNORED;
    sout  = '0;
    edev  = '0;
    eclu  = '0;
    euc   = 1'b0;
    ptr_d = ptr_q;
    case (mode_q)
      MODE_ACQUIRE: begin
        if (hit_f_q) begin
          we       = 1'b1;
          wr.users = (eff.users == 8'hFF) ? 8'hFF : eff.users + 8'd1;
          wr.stamp = now_q;
          st       = STS_HIT;
          sout     = 6'(target_q);
        end else if (free_f_q || old_f_q || rot_f_q) begin
          we         = 1'b1;
          wr.state   = SS_VALID;
          wr.users   = 8'd1;
          wr.stamp   = now_q;
          wr.device  = dev_q;
          wr.cluster = clu_q;
          sout       = 6'(target_q);
          if (free_f_q) begin
            st = STS_FILL;
          end else if (eff.state == SS_DIRTY_N || eff.state == SS_DIRTY_U) begin
            st   = STS_DIRTY_EV;
            edev = eff.device;
            eclu = eff.cluster;
            euc  = (eff.state == SS_DIRTY_U);
          end else begin
            st = STS_CLEAN_EV;
          end
          if (!free_f_q && !old_f_q) begin
            ptr_d = rot_q;
          end
        end else begin
          st = STS_FULL;
        end
      end
      MODE_RELEASE: begin
        if (in_range && eff.users != 8'd0) begin
          we       = 1'b1;
          wr.users = eff.users - 8'd1;
          if (eff.users == 8'd1 && eff.state == SS_DELETED) begin
            wr.state = SS_FREE;
          end
          st   = STS_RELEASED;
          sout = slot_q;
        end
      end
      MODE_DIRTY: begin
        if (in_range) begin
          if (ro_q) begin
            st = STS_READ_ONLY;
          end else if (eff.state == SS_VALID || eff.state == SS_DIRTY_N ||
                       eff.state == SS_DIRTY_U) begin
            sout = slot_q;
            if (wbe_q) begin
              we       = 1'b1;
              wr.state = ucf_q ? SS_DIRTY_U : SS_DIRTY_N;
              st       = STS_DIRTIED;
            end else begin
              st = STS_WRITE_THR;
            end
          end
        end
      end
      MODE_DELETE: begin
        if (hit_f_q) begin
          we       = 1'b1;
          wr.stamp = now_q;
          wr.state = (eff.users == 8'd0) ? SS_FREE : SS_DELETED;
          st       = STS_DELETED;
          sout     = 6'(target_q);
        end
      end
      default: st = STS_IGNORED;
    endcase
    we = we && cmd_i.exec;
  end

  // control state: valid bits, rotating pointer, configuration, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      ptr_q       <= '0;
      wbe_q       <= 1'b0;
      ro_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (we) begin
        v_q[target_q] <= 1'b1;
      end
      if (cmd_i.exec) begin
        ptr_q <= ptr_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WRITE_BACK: wbe_q <= cfg_data_i[0];
          CFG_READ_ONLY:  ro_q  <= cfg_data_i[0];
          default:        ro_q  <= ro_q;
        endcase
      end
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_o             <= st;
      slot_out_o           <= sout;
      evict_device_o       <= edev;
      evict_cluster_o      <= eclu;
      evict_uncompressed_o <= euc;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== design/cluster_cache_slot_manager.sv =====
// Top level of the cluster cache slot manager: controller plus datapath.
// Depends on ccsm_pkg, ccsm_ctrl, ccsm_dp.
//
// Fully associative table of SLOTS cache slots with LRU replacement. One
// transaction is worked at a time. Acquire and delete walk the slot table
// through the single read port of the slot RAM, one slot a cycle, and an
// acquire that finds no free and no aged idle slot walks the table a second
// time for the rotating pointer. Release and mark-dirty read one slot. The
// result sits in an output register, so a new transaction is accepted while
// it waits. No clearing pass after reset: per-slot valid bits make the table
// read as empty at once.
`timescale 1ns / 1ps
`default_nettype none
module cluster_cache_slot_manager #(
  parameter int SLOTS = ccsm_pkg::DEF_SLOTS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [1:0]                      mode_i,
  input  wire logic [15:0]                     device_i,
  input  wire logic [27:0]                     cluster_i,
  input  wire logic [5:0]                      slot_i,
  input  wire logic [31:0]                     now_i,
  input  wire logic                            uncompressed_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [3:0]                           status_o,
  output logic [5:0]                           slot_out_o,
  output logic [15:0]                          evict_device_o,
  output logic [27:0]                          evict_cluster_o,
  output logic                                 evict_uncompressed_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [ccsm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ccsm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ccsm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ccsm_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .mode_i    (mode_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ccsm_dp #(.SLOTS(SLOTS)) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .mode_i              (mode_i),
    .device_i            (device_i),
    .cluster_i           (cluster_i),
    .slot_i              (slot_i),
    .now_i               (now_i),
    .uncompressed_i      (uncompressed_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .slot_out_o          (slot_out_o),
    .evict_device_o      (evict_device_o),
    .evict_cluster_o     (evict_cluster_o),
    .evict_uncompressed_o(evict_uncompressed_o)
  );

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a transaction is in flight");

  // a new result only comes out of a transaction in flight
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a transaction");

  // full, read-only and ignored carry no slot
  a_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STS_FULL || status_o == STS_READ_ONLY ||
                    status_o == STS_IGNORED) |-> slot_out_o == 6'd0)
    else $error("slot reported with a slotless status");

  // victim tag only on a dirty eviction
  a_evict_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STS_DIRTY_EV |->
      evict_device_o == 16'd0 && evict_cluster_o == 28'd0 && !evict_uncompressed_o)
    else $error("victim tag without a dirty eviction");

endmodule
`default_nettype wire
